// ===== sv/cac_pkg.sv =====
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types, register codes and helpers for the coverage alpha compositor.
// ----------------------------------------------------------------------------
package cac_pkg;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [2:0] REG_RED    = 3'd0;
    localparam logic [2:0] REG_GREEN  = 3'd1;
    localparam logic [2:0] REG_BLUE   = 3'd2;
    localparam logic [2:0] REG_ALPHA  = 3'd3;
    localparam logic [2:0] REG_UNDER  = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;

    // fragment queue between the front and the back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stages in the back pipeline, output register included
    localparam int BACK_STAGES = 4;

    // live configuration as seen by the datapath
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        under;
        logic [13:0] w_lim;
        logic [13:0] h_lim;
    } t_cfg;

    // one classified fragment waiting in the queue
    typedef struct packed {
        logic [31:0] dst;
        logic [15:0] prod;
        logic        skip;
    } t_frag;

    // queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // truncating divide by 255 for a product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ===== sv/cac_front.sv =====
// ----------------------------------------------------------------------------
// cac_front
// Accepts pixel beats, checks surface bounds and skip conditions, forms the
// coverage times paint alpha product and pushes the fragment to the queue.
// ----------------------------------------------------------------------------
module cac_front
    import cac_pkg::*;
(
    input  logic              i_valid,
    input  logic signed [13:0] i_pixel_x,
    input  logic signed [13:0] i_pixel_y,
    input  logic [7:0]        i_coverage,
    input  logic [31:0]       i_dst_pixel,
    input  t_cfg              i_cfg,
    input  t_qstat            i_qstat,
    output logic              o_stall,
    output logic              o_push,
    output t_frag             o_entry
);

    logic x_ok;
    logic y_ok;

    // bounds: negative coordinates are outside
    assign x_ok = !i_pixel_x[13] && ({1'b0, i_pixel_x[12:0]} < i_cfg.w_lim);
    assign y_ok = !i_pixel_y[13] && ({1'b0, i_pixel_y[12:0]} < i_cfg.h_lim);

    // handshake toward the source
    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // fragment record
    always_comb begin
        o_entry.dst  = i_dst_pixel;
        o_entry.prod = i_coverage * i_cfg.alpha;
        o_entry.skip = !x_ok || !y_ok || (i_cfg.alpha == 8'd0) || (i_coverage == 8'd0);
    end

endmodule

// ===== sv/cac_queue.sv =====
// ----------------------------------------------------------------------------
// cac_queue
// Small register queue that decouples classification from compositing.
// ----------------------------------------------------------------------------
module cac_queue
    import cac_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frag  i_entry,
    input  logic   i_pop,
    output t_frag  o_head,
    output t_qstat o_qstat
);

    t_frag              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== sv/cac_back.sv =====
// ----------------------------------------------------------------------------
// cac_back
// Compositing pipeline: fragment alpha, channel products, divides by 255 and
// the final over or under blend, ending in the output register.
// ----------------------------------------------------------------------------
module cac_back
    import cac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frag       i_head,
    input  t_qstat      i_qstat,
    input  t_cfg        i_cfg,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [31:0] o_new_pixel,
    output logic        o_write_enable
);

    logic        adv;
    logic        r_v1, r_v2, r_v3, r_v4;

    // stage 1 registers
    logic [31:0] r1_dst;
    logic [7:0]  r1_sa;
    logic        r1_skip;
    logic [7:0]  sa;

    // stage 2 registers
    logic [31:0] r2_dst;
    logic [7:0]  r2_sa;
    logic [7:0]  r2_id;
    logic        r2_skip;
    logic [15:0] r2_p [3];
    logic [15:0] r2_q [4];
    logic [15:0] r2_a;
    logic [15:0] n2_p [3];
    logic [15:0] n2_q [4];
    logic [7:0]  is_w;
    logic [7:0]  id_w;

    // stage 3 registers
    logic [31:0] r3_dst;
    logic [7:0]  r3_sa;
    logic        r3_skip;
    logic [7:0]  r3_dp [3];
    logic [7:0]  r3_dq [4];
    logic [15:0] r3_u [3];
    logic [7:0]  r3_da;
    logic [7:0]  n3_dp [3];
    logic [7:0]  n3_dq [4];
    logic [15:0] n3_u [3];

    // output stage
    logic [31:0] r_pixel;
    logic        r_we;
    logic [31:0] n_pixel;

    // whole pipeline moves unless the output beat is held
    assign adv   = !(r_v4 && i_stall);
    assign o_pop = adv && !i_qstat.empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: fragment alpha
    assign sa = div255(i_head.prod);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_dst  <= i_head.dst;
            r1_sa   <= sa;
            r1_skip <= i_head.skip || (sa == 8'd0);
        end
    end

    // stage 2: paint and destination products
    assign is_w = 8'd255 - r1_sa;
    assign id_w = 8'd255 - r1_dst[31:24];

    always_comb begin
        n2_p[0] = i_cfg.red   * r1_sa;
        n2_p[1] = i_cfg.green * r1_sa;
        n2_p[2] = i_cfg.blue  * r1_sa;
        for (int i = 0; i < 4; i++) begin
            n2_q[i] = r1_dst[8*i +: 8] * is_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_dst  <= r1_dst;
            r2_sa   <= r1_sa;
            r2_id   <= id_w;
            r2_skip <= r1_skip;
            r2_p    <= n2_p;
            r2_q    <= n2_q;
            r2_a    <= r1_sa * id_w;
        end
    end

    // stage 3: first divides, under-mode second product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_dp[i] = div255(r2_p[i]);
            n3_u[i]  = n3_dp[i] * r2_id;
        end
        for (int i = 0; i < 4; i++) begin
            n3_dq[i] = div255(r2_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_dst  <= r2_dst;
            r3_sa   <= r2_sa;
            r3_skip <= r2_skip;
            r3_dp   <= n3_dp;
            r3_dq   <= n3_dq;
            r3_u    <= n3_u;
            r3_da   <= div255(r2_a);
        end
    end

    // stage 4: blend, channels wrap to 8 bits
    always_comb begin
        n_pixel = r3_dst;
        if (!r3_skip) begin
            if (i_cfg.under) begin
                for (int i = 0; i < 3; i++) begin
                    n_pixel[8*i +: 8] = r3_dst[8*i +: 8] + div255(r3_u[i]);
                end
                n_pixel[31:24] = r3_dst[31:24] + r3_da;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    n_pixel[8*i +: 8] = r3_dp[i] + r3_dq[i];
                end
                n_pixel[31:24] = r3_sa + r3_dq[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pixel <= n_pixel;
            r_we    <= !r3_skip;
        end
    end

    assign o_valid        = r_v4;
    assign o_new_pixel    = r_pixel;
    assign o_write_enable = r_we;

endmodule

// ===== sv/coverage_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// coverage_alpha_compositor
// Blends a paint colour, scaled by glyph coverage, over or under a
// premultiplied RGBA8888 destination pixel.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_stall      i_pixel_x, i_pixel_y,
//                                                    i_coverage, i_dst_pixel
//  out       source     o_out_valid / i_out_stall    o_new_pixel,
//                                                    o_write_enable
//  config    sink       psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  one beat per cycle in and out while neither side stalls; an accepted beat
//  is written to the queue at the accepting edge, then passes four back stages
//  a four-entry fragment queue keeps input taking beats while the output
//  is stalled; o_in_stall rises only when the queue is full
//  synchronous active-low reset clears control state and loads register
//  defaults; the datapath registers are not reset
// ----------------------------------------------------------------------------
module coverage_alpha_compositor
    import cac_pkg::*;
#(
    parameter int MAX_SURFACE = 4096
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [13:0] i_pixel_x,
    input  logic signed [13:0] i_pixel_y,
    input  logic [7:0]         i_coverage,
    input  logic [31:0]        i_dst_pixel,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_new_pixel,
    output logic               o_write_enable,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [13:0] MAX_LIM = 14'(MAX_SURFACE);
    localparam int          INFLIGHT_MAX = QDEPTH + BACK_STAGES;
    localparam int          INFLIGHT_W = $clog2(INFLIGHT_MAX + 1);

    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;
    logic        r_under;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    t_cfg        cfg;

    logic        push;
    t_frag       entry;
    logic        pop;
    t_frag       head;
    t_qstat      qstat;

    logic        in_acc;
    logic        out_acc;
    logic [INFLIGHT_W-1:0] r_inflight;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= 8'd0;
            r_green  <= 8'd0;
            r_blue   <= 8'd0;
            r_alpha  <= 8'd255;
            r_under  <= 1'b0;
            r_width  <= 13'd4096;
            r_height <= 13'd4096;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RED:    r_red    <= pwdata[7:0];
                REG_GREEN:  r_green  <= pwdata[7:0];
                REG_BLUE:   r_blue   <= pwdata[7:0];
                REG_ALPHA:  r_alpha  <= pwdata[7:0];
                REG_UNDER:  r_under  <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[12:0];
                REG_HEIGHT: r_height <= pwdata[12:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_RED:    prdata = {24'd0, r_red};
            REG_GREEN:  prdata = {24'd0, r_green};
            REG_BLUE:   prdata = {24'd0, r_blue};
            REG_ALPHA:  prdata = {24'd0, r_alpha};
            REG_UNDER:  prdata = {31'd0, r_under};
            REG_WIDTH:  prdata = {19'd0, r_width};
            REG_HEIGHT: prdata = {19'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    // live configuration, surface size saturated to the maximum
    always_comb begin
        cfg.red   = r_red;
        cfg.green = r_green;
        cfg.blue  = r_blue;
        cfg.alpha = r_alpha;
        cfg.under = r_under;
        cfg.w_lim = ({1'b0, r_width}  > MAX_LIM) ? MAX_LIM : {1'b0, r_width};
        cfg.h_lim = ({1'b0, r_height} > MAX_LIM) ? MAX_LIM : {1'b0, r_height};
    end

    // classification
    cac_front u_front (
        .i_valid     (i_in_valid),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_coverage  (i_coverage),
        .i_dst_pixel (i_dst_pixel),
        .i_cfg       (cfg),
        .i_qstat     (qstat),
        .o_stall     (o_in_stall),
        .o_push      (push),
        .o_entry     (entry)
    );

    // fragment queue
    cac_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_qstat (qstat)
    );

    // compositing
    cac_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .i_cfg          (cfg),
        .i_stall        (i_out_stall),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable)
    );

    // beats held inside the block
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + INFLIGHT_W'(in_acc) - INFLIGHT_W'(out_acc);
        end
    end

    // checks
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_inflight < INFLIGHT_W'(INFLIGHT_MAX)))
        else $error("beat accepted with block full");

    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_inflight != '0))
        else $error("output beat with nothing in flight");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_inflight >= INFLIGHT_W'(QDEPTH)))
        else $error("input stalled while queue cannot be full");

endmodule

// ===== tb/coverage_alpha_compositor_tb.sv =====
// ----------------------------------------------------------------------------
// coverage_alpha_compositor_tb
// Self-checking bench for the coverage alpha compositor. A table of directed
// beats and register writes covers the surface edges, the skip conditions,
// both blend modes and channel wrap. Random phases follow, each with fresh
// register settings. Each result beat is checked in order against a table
// value or a local blend model, with random input gaps and output stall.
// ----------------------------------------------------------------------------
module coverage_alpha_compositor_tb
    import cac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int SURF_MAX     = 4096;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_BEATS  = 183;
    localparam int DIR_ROWS     = 37;

    // paint settings mirrored from the register port
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        under;
        logic [12:0] width;
        logic [12:0] height;
    } t_paint_cfg;

    typedef struct packed {
        logic [31:0] pixel;
        logic        we;
    } t_pixel_result;

    typedef enum logic {ROW_REG, ROW_BEAT} t_row_kind;

    // one directed step: a register write or a pixel beat
    typedef struct packed {
        t_row_kind          kind;
        logic [2:0]         reg_idx;
        logic [31:0]        reg_val;
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic [7:0]         cov;
        logic [31:0]        dst;
        logic               fixed_exp;
        logic [31:0]        exp_pixel;
        logic               exp_we;
    } t_dir_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic signed [13:0] i_pixel_x      = '0;
    logic signed [13:0] i_pixel_y      = '0;
    logic [7:0]         i_coverage     = '0;
    logic [31:0]        i_dst_pixel    = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [31:0]        o_new_pixel;
    logic               o_write_enable;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [4:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    t_paint_cfg    paint_cfg = '{8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 13'd4096, 13'd4096};
    t_pixel_result expected_pixels [$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    bit            in_quiet       = 1'b0;
    bit            out_stalled    = 1'b0;
    int            seg_left       = 0;

    t_dir_row dir_table [DIR_ROWS] = '{
        // reset settings: opaque black over anything, then the skip cases
        '{ROW_BEAT, REG_RED, 32'd0, 14'd0, 14'd0, 8'd255, 32'h12345678, 1'b1, 32'hFF000000, 1'b1},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd4095, 14'd4095, 8'd255, 32'h0, 1'b1, 32'hFF000000, 1'b1},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd4096, 14'd0, 8'd255, 32'hA1B2C3D4, 1'b1, 32'hA1B2C3D4, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd0, 14'd4096, 8'd255, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'h3FFF, 14'd5, 8'd255, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd3, 14'h2000, 8'd200, 32'h01020304, 1'b1, 32'h01020304, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'h1FFF, 14'h1FFF, 8'd255, 32'h0, 1'b1, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd10, 14'd10, 8'd0, 32'h80402010, 1'b1, 32'h80402010, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd10, 14'd10, 8'd128, 32'h80402010, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd1, 14'd1, 8'd1, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
        // tiny paint alpha: fragment alpha truncates to zero below full coverage
        '{ROW_REG, REG_RED, 32'd255, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_GREEN, 32'h80, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_BLUE, 32'd1, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_ALPHA, 32'd1, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd20, 14'd30, 8'd254, 32'h11223344, 1'b1, 32'h11223344, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd20, 14'd30, 8'd255, 32'h11223344, 1'b0, 32'h0, 1'b0},
        // paint alpha zero disables every write
        '{ROW_REG, REG_ALPHA, 32'd0, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd5, 14'd5, 8'd255, 32'h00FF00FF, 1'b1, 32'h00FF00FF, 1'b0},
        // under mode, including channel wrap and an opaque destination
        '{ROW_REG, REG_ALPHA, 32'd200, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_UNDER, 32'd1, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd10, 14'd10, 8'd255, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd10, 14'd10, 8'd255, 32'h40FF80FF, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd10, 14'd10, 8'd255, 32'hFF102030, 1'b1, 32'hFF102030, 1'b1},
        // zero width: nothing is inside
        '{ROW_REG, REG_WIDTH, 32'd0, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd0, 14'd0, 8'd255, 32'hC0C0C0C0, 1'b1, 32'hC0C0C0C0, 1'b0},
        // oversized width saturates, one-row surface
        '{ROW_REG, REG_WIDTH, 32'd8191, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_HEIGHT, 32'd1, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd4095, 14'd0, 8'd77, 32'h20181008, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd4096, 14'd0, 8'd77, 32'h20181008, 1'b1, 32'h20181008, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd0, 14'd1, 8'd77, 32'h20181008, 1'b1, 32'h20181008, 1'b0},
        // back to source over with an oversized height
        '{ROW_REG, REG_UNDER, 32'd0, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_REG, REG_HEIGHT, 32'd8191, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd100, 14'd4095, 8'd160, 32'h99663300, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd7, 14'd7, 8'd255, 32'h7F3F1F0F, 1'b0, 32'h0, 1'b0},
        // one-column surface
        '{ROW_REG, REG_WIDTH, 32'd1, 14'd0, 14'd0, 8'd0, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd0, 14'd9, 8'd90, 32'h40302010, 1'b0, 32'h0, 1'b0},
        '{ROW_BEAT, REG_RED, 32'd0, 14'd1, 14'd9, 8'd90, 32'h40302010, 1'b1, 32'h40302010, 1'b0}
    };

    coverage_alpha_compositor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_coverage     (i_coverage),
        .i_dst_pixel    (i_dst_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_new_pixel    (o_new_pixel),
        .o_write_enable (o_write_enable),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // composite one coverage sample into a destination pixel
    function automatic t_pixel_result blend_pixel(input t_paint_cfg c,
                                                  input logic signed [13:0] x,
                                                  input logic signed [13:0] y,
                                                  input logic [7:0] cov,
                                                  input logic [31:0] dst);
        t_pixel_result r;
        int w_lim;
        int h_lim;
        int xi;
        int yi;
        int sa;
        int inv;
        int paint [3];
        int ch [4];
        r.pixel = dst;
        r.we    = 1'b0;
        w_lim = (int'(c.width) > SURF_MAX) ? SURF_MAX : int'(c.width);
        h_lim = (int'(c.height) > SURF_MAX) ? SURF_MAX : int'(c.height);
        xi = x;
        yi = y;
        if (xi < 0 || yi < 0 || xi >= w_lim || yi >= h_lim || c.alpha == 0 || cov == 0)
            return r;
        sa = int'(cov) * int'(c.alpha) / 255;
        if (sa == 0)
            return r;
        paint[0] = c.red;
        paint[1] = c.green;
        paint[2] = c.blue;
        for (int i = 0; i < 4; i++)
            ch[i] = int'(dst[8*i +: 8]);
        if (c.under) begin
            // slide the paint beneath the existing ink
            inv = 255 - ch[3];
            for (int i = 0; i < 3; i++)
                ch[i] = (ch[i] + paint[i] * sa / 255 * inv / 255) & 255;
            ch[3] = (ch[3] + sa * inv / 255) & 255;
        end else begin
            inv = 255 - sa;
            for (int i = 0; i < 3; i++)
                ch[i] = (paint[i] * sa / 255 + ch[i] * inv / 255) & 255;
            ch[3] = (sa + ch[3] * inv / 255) & 255;
        end
        r.pixel = {8'(ch[3]), 8'(ch[2]), 8'(ch[1]), 8'(ch[0])};
        r.we    = 1'b1;
        return r;
    endfunction

    // idle cycles before the next input beat: mostly none, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // drive one input beat and hold it until accepted
    task automatic send_pixel(input logic signed [13:0] x, input logic signed [13:0] y,
                              input logic [7:0] cov, input logic [31:0] dst,
                              input t_pixel_result want);
        int gap;
        i_in_valid  <= 1'b1;
        i_pixel_x   <= x;
        i_pixel_y   <= y;
        i_coverage  <= cov;
        i_dst_pixel <= dst;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_pixels.push_back(want);
        gap = pick_gap(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register write once the block has drained: setup then access
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RED:    paint_cfg.red    = val[7:0];
            REG_GREEN:  paint_cfg.green  = val[7:0];
            REG_BLUE:   paint_cfg.blue   = val[7:0];
            REG_ALPHA:  paint_cfg.alpha  = val[7:0];
            REG_UNDER:  paint_cfg.under  = val[0];
            REG_WIDTH:  paint_cfg.width  = val[12:0];
            REG_HEIGHT: paint_cfg.height = val[12:0];
            default: ;
        endcase
    endtask

    // result check and output stall pattern
    always @(posedge i_clk) begin
        t_pixel_result want;
        int r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result beat: pixel %h we %b",
                                 o_new_pixel, o_write_enable);
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_new_pixel !== want.pixel || o_write_enable !== want.we) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("mismatch: pixel exp %h got %h, we exp %b got %b",
                                     want.pixel, o_new_pixel, want.we, o_write_enable);
                    end
                end
            end
            // alternate free runs with stall bursts, some of each long
            if (seg_left == 0) begin
                if (out_stalled) begin
                    out_stalled = 1'b0;
                    seg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                           : $urandom_range(0, 8);
                end else begin
                    out_stalled = 1'b1;
                    r = $urandom_range(0, 99);
                    seg_left = (r < 70) ? $urandom_range(0, 1) :
                               (r < 95) ? $urandom_range(2, 7) : $urandom_range(20, 60);
                end
                i_out_stall <= out_stalled;
            end else begin
                seg_left--;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_pixel_result      want;
        t_dir_row           row;
        int                 w_eff;
        int                 h_eff;
        int                 sel;
        logic signed [13:0] px;
        logic signed [13:0] py;
        logic [7:0]         cov;
        logic [31:0]        dst;
        logic [7:0]         a;
        logic [31:0]        v_red;
        logic [31:0]        v_green;
        logic [31:0]        v_blue;
        logic [31:0]        v_alpha;
        logic [31:0]        v_under;
        logic [31:0]        v_width;
        logic [31:0]        v_height;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_table[i];
            if (row.kind == ROW_REG) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (row.fixed_exp)
                    want = '{row.exp_pixel, row.exp_we};
                else
                    want = blend_pixel(paint_cfg, row.x, row.y, row.cov, row.dst);
                send_pixel(row.x, row.y, row.cov, row.dst, want);
            end
        end

        // random phases, each with its own settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) begin
                v_red = 255; v_green = 255; v_blue = 255; v_alpha = 255;
                v_under = 0; v_width = 4096; v_height = 4096;
            end else if (ph == 1) begin
                v_red = 0; v_green = 0; v_blue = 0; v_alpha = 1;
                v_under = 1; v_width = 1; v_height = 1;
            end else begin
                v_red   = $urandom_range(0, 255);
                v_green = $urandom_range(0, 255);
                v_blue  = $urandom_range(0, 255);
                sel = $urandom_range(0, 7);
                v_alpha = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 255 :
                          $urandom_range(0, 255);
                v_under = $urandom_range(0, 1);
                sel = $urandom_range(0, 7);
                v_width = (sel == 0) ? 0 : (sel == 1) ? 4096 : (sel == 2) ? 8191 :
                          (sel == 3) ? $urandom_range(4097, 8191) :
                          (sel < 6) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
                sel = $urandom_range(0, 7);
                v_height = (sel == 0) ? 1 : (sel == 1) ? 4096 : (sel == 2) ? 8191 :
                           (sel < 5) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
            end
            write_reg(REG_RED, v_red);
            write_reg(REG_GREEN, v_green);
            write_reg(REG_BLUE, v_blue);
            write_reg(REG_ALPHA, v_alpha);
            write_reg(REG_UNDER, v_under);
            write_reg(REG_WIDTH, v_width);
            write_reg(REG_HEIGHT, v_height);
            w_eff = (int'(paint_cfg.width) > SURF_MAX) ? SURF_MAX : int'(paint_cfg.width);
            h_eff = (int'(paint_cfg.height) > SURF_MAX) ? SURF_MAX : int'(paint_cfg.height);

            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (n % 60 == 0)
                    in_quiet = ($urandom_range(0, 3) == 0);
                // coordinates: mostly on the surface, some on its edges, some anywhere
                sel = $urandom_range(0, 9);
                if (sel < 7 && w_eff > 0 && h_eff > 0) begin
                    px = 14'($urandom_range(0, w_eff - 1));
                    py = 14'($urandom_range(0, h_eff - 1));
                end else if (sel == 8) begin
                    case ($urandom_range(0, 2))
                        0: px = -14'sd1;
                        1: px = 14'(w_eff - 1);
                        default: px = 14'(w_eff);
                    endcase
                    py = (h_eff > 0) ? 14'($urandom_range(0, h_eff - 1)) : 14'sd0;
                end else if (sel == 9) begin
                    case ($urandom_range(0, 2))
                        0: py = -14'sd1;
                        1: py = 14'(h_eff - 1);
                        default: py = 14'(h_eff);
                    endcase
                    px = (w_eff > 0) ? 14'($urandom_range(0, w_eff - 1)) : 14'sd0;
                end else begin
                    px = 14'($urandom);
                    py = 14'($urandom);
                end
                sel = $urandom_range(0, 9);
                cov = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : (sel == 2) ? 8'd1 :
                      8'($urandom_range(0, 255));
                // destination: mostly well-formed premultiplied, else raw bits
                if ($urandom_range(0, 9) < 7) begin
                    a = 8'($urandom_range(0, 255));
                    dst = {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                           8'($urandom_range(0, a))};
                end else begin
                    dst = $urandom;
                end
                want = blend_pixel(paint_cfg, px, py, cov, dst);
                send_pixel(px, py, cov, dst, want);
            end
        end

        // drain and report
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/cac_pkg.sv
sv/cac_front.sv
sv/cac_queue.sv
sv/cac_back.sv
sv/coverage_alpha_compositor.sv
tb/coverage_alpha_compositor_tb.sv
